[rtl/ict_pkg.sv]
// Shared widths, constants and bundle types for the in-circle test pipeline.
package ict_pkg;

    localparam int CHUNK_W = 32;
    localparam int TOL_W = 16;
    localparam logic [TOL_W-1:0] TOL_RESET = 16'd7;

    localparam int DW = 33;
    localparam int SQ_W = 2 * DW;
    localparam int S_W = SQ_W + 1;
    localparam int W_W = S_W + 1;
    localparam int A_W = S_W + 2;
    localparam int AE_W = A_W + 1;
    localparam int TD_W = S_W;
    localparam int M2_W = S_W + DW;
    localparam int TNF_W = W_W + DW;
    localparam int G_W = M2_W + 1;
    localparam int M3_W = G_W + DW;
    localparam int TN_W = M3_W + 1;
    localparam int P_W = AE_W + TD_W;
    localparam int R_W = P_W + 1;

    typedef logic signed [DW-1:0] diff_t;

    typedef struct packed {
        diff_t u1;
        diff_t v1;
        diff_t u3;
        diff_t v3;
        diff_t qx;
        diff_t qy;
        logic  flat1;
        logic  flat3;
        logic  zv;
    } geo_t;

    typedef struct packed {
        diff_t qx;
        diff_t qy;
        logic  flat_any;
        logic  deg;
    } tail_t;

    typedef struct packed {
        logic flat_any;
        logic deg;
    } flag_t;

    typedef struct packed {
        logic signed [AE_W-1:0] ame;
        logic signed [TD_W-1:0] td;
    } mulop_t;

    typedef struct packed {
        logic signed [TN_W-1:0] tn;
        logic                   td_neg;
        logic                   deg;
    } fin_t;

endpackage

[rtl/ict_dly.sv]
// Enabled register chain that keeps side data aligned with the pipeline.
module ict_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] sh_reg [N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg[0] <= d;
            for (int k = 1; k < N; k++)
            begin
                sh_reg[k] <= sh_reg[k-1];
            end
        end
    end

    assign q = sh_reg[N-1];
endmodule

[rtl/ict_mul.sv]
// Signed multiplier split into 33 by 33 bit partial products over three stages.
module ict_mul #(
    parameter int WA = 33,
    parameter int WB = 33
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [WA-1:0]      a,
    input  logic signed [WB-1:0]      b,
    output logic signed [WA+WB-1:0]   p
);
    import ict_pkg::*;

    localparam int NA = (WA + CHUNK_W - 1) / CHUNK_W;
    localparam int NB = (WB + CHUNK_W - 1) / CHUNK_W;
    localparam int WP = WA + WB;
    localparam int AXW = NA * CHUNK_W;
    localparam int BXW = NB * CHUNK_W;
    localparam int PPW = 2 * CHUNK_W + 2;

    logic signed [AXW-1:0]     ax;
    logic signed [BXW-1:0]     bx;
    logic signed [CHUNK_W:0]   ca [NA];
    logic signed [CHUNK_W:0]   cb [NB];
    logic signed [PPW-1:0]     pp_next [NA][NB];
    logic signed [PPW-1:0]     pp_reg  [NA][NB];
    logic signed [WP-1:0]      row_next [NA];
    logic signed [WP-1:0]      row_reg  [NA];
    logic signed [WP-1:0]      prod_next;
    logic signed [WP-1:0]      prod_reg;

    assign ax = AXW'(a);
    assign bx = BXW'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (i == NA - 1)
                ca[i] = $signed({ax[CHUNK_W*i+CHUNK_W-1], ax[CHUNK_W*i +: CHUNK_W]});
            else
                ca[i] = $signed({1'b0, ax[CHUNK_W*i +: CHUNK_W]});
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == NB - 1)
                cb[j] = $signed({bx[CHUNK_W*j+CHUNK_W-1], bx[CHUNK_W*j +: CHUNK_W]});
            else
                cb[j] = $signed({1'b0, bx[CHUNK_W*j +: CHUNK_W]});
        end
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = PPW'(ca[i]) * PPW'(cb[j]);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (WP'(pp_reg[i][j]) << (CHUNK_W * j));
            end
        end
        prod_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            prod_next = prod_next + (row_reg[i] << (CHUNK_W * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg   <= pp_next;
            row_reg  <= row_next;
            prod_reg <= prod_next;
        end
    end

    assign p = prod_reg;
endmodule

[rtl/incircle_circumcenter_test.sv]
// Exact in-circle test of a query point against a triangle's circumcircle.
// Throughput is one request per cycle; a stalled result holds the whole pipeline.
// The depth is set by four chained wide multiplies of three stages each.
// Reset clears the valid bits and loads the tolerance register with 7.
module incircle_circumcenter_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [ict_pkg::TOL_W-1:0]    cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [31:0]           query_x,
    input  logic signed [31:0]           query_y,
    input  logic signed [31:0]           first_x,
    input  logic signed [31:0]           first_y,
    input  logic signed [31:0]           second_x,
    input  logic signed [31:0]           second_y,
    input  logic signed [31:0]           third_x,
    input  logic signed [31:0]           third_y,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         inside_res,
    output logic                         degenerate
);
    import ict_pkg::*;

    localparam int EW = TOL_W + FRAC_BITS;
    localparam int NSTG = 17;

    logic [TOL_W-1:0] tol_reg;
    logic [NSTG-1:0]  vld_reg;
    logic             en;

    geo_t  geo1_reg;
    geo_t  geo1_next;
    logic [DW-1:0] abs1;
    logic [DW-1:0] abs3;

    assign en = !(vld_reg[NSTG-1] && out_stall);
    assign in_stall = !en;
    assign out_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                tol_reg <= cfg_wdata;
            if (en)
                vld_reg <= {vld_reg[NSTG-2:0], in_valid};
        end
    end

    always_comb
    begin
        geo1_next.u1 = DW'(first_x) - DW'(second_x);
        geo1_next.v1 = DW'(first_y) - DW'(second_y);
        geo1_next.u3 = DW'(third_x) - DW'(second_x);
        geo1_next.v3 = DW'(third_y) - DW'(second_y);
        geo1_next.qx = DW'(query_x) - DW'(second_x);
        geo1_next.qy = DW'(query_y) - DW'(second_y);
        abs1 = geo1_next.v1[DW-1] ? DW'(-geo1_next.v1) : DW'(geo1_next.v1);
        abs3 = geo1_next.v3[DW-1] ? DW'(-geo1_next.v3) : DW'(geo1_next.v3);
        geo1_next.flat1 = abs1 < DW'(tol_reg);
        geo1_next.flat3 = abs3 < DW'(tol_reg);
        geo1_next.zv = (geo1_next.v1 == '0) || (geo1_next.v3 == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            geo1_reg <= geo1_next;
    end

    logic signed [SQ_W-1:0] m_uu1, m_vv1, m_uu3, m_vv3, m_qxx, m_qyy;
    logic signed [SQ_W-1:0] m_u13, m_qxu1, m_qxu3, m_u1v3, m_u3v1;

    ict_mul #(.WA(DW), .WB(DW)) u_m_uu1 (.clk, .en, .a(geo1_reg.u1), .b(geo1_reg.u1), .p(m_uu1));
    ict_mul #(.WA(DW), .WB(DW)) u_m_vv1 (.clk, .en, .a(geo1_reg.v1), .b(geo1_reg.v1), .p(m_vv1));
    ict_mul #(.WA(DW), .WB(DW)) u_m_uu3 (.clk, .en, .a(geo1_reg.u3), .b(geo1_reg.u3), .p(m_uu3));
    ict_mul #(.WA(DW), .WB(DW)) u_m_vv3 (.clk, .en, .a(geo1_reg.v3), .b(geo1_reg.v3), .p(m_vv3));
    ict_mul #(.WA(DW), .WB(DW)) u_m_qxx (.clk, .en, .a(geo1_reg.qx), .b(geo1_reg.qx), .p(m_qxx));
    ict_mul #(.WA(DW), .WB(DW)) u_m_qyy (.clk, .en, .a(geo1_reg.qy), .b(geo1_reg.qy), .p(m_qyy));
    ict_mul #(.WA(DW), .WB(DW)) u_m_u13 (.clk, .en, .a(geo1_reg.u1), .b(geo1_reg.u3), .p(m_u13));
    ict_mul #(.WA(DW), .WB(DW)) u_m_qxu1 (.clk, .en, .a(geo1_reg.qx), .b(geo1_reg.u1), .p(m_qxu1));
    ict_mul #(.WA(DW), .WB(DW)) u_m_qxu3 (.clk, .en, .a(geo1_reg.qx), .b(geo1_reg.u3), .p(m_qxu3));
    ict_mul #(.WA(DW), .WB(DW)) u_m_u1v3 (.clk, .en, .a(geo1_reg.u1), .b(geo1_reg.v3), .p(m_u1v3));
    ict_mul #(.WA(DW), .WB(DW)) u_m_u3v1 (.clk, .en, .a(geo1_reg.u3), .b(geo1_reg.v1), .p(m_u3v1));

    geo_t geo4;

    ict_dly #(.W($bits(geo_t)), .N(3)) u_dly_geo (.clk, .en, .d(geo1_reg), .q(geo4));

    logic [EW-1:0]          e_w;
    logic signed [S_W-1:0]  s1_w, s3_w, q2_w, tdg_w;
    logic signed [W_W-1:0]  w_w;
    logic signed [A_W-1:0]  aflat_w, asel_w;
    mulop_t                 mulop5_next;
    logic                   flat_any_w;
    logic                   deg_w;

    logic signed [S_W-1:0]  s1_reg, s3_reg;
    logic signed [W_W-1:0]  w_reg;
    geo_t                   geo5_reg;
    mulop_t                 mulop5_reg;
    logic                   flat_any5_reg;
    logic                   deg5_reg;

    always_comb
    begin
        e_w = {tol_reg, {FRAC_BITS{1'b0}}};
        s1_w = S_W'(m_uu1) + S_W'(m_vv1);
        s3_w = S_W'(m_uu3) + S_W'(m_vv3);
        q2_w = S_W'(m_qxx) + S_W'(m_qyy);
        tdg_w = S_W'(m_u1v3) - S_W'(m_u3v1);
        flat_any_w = geo4.flat1 || geo4.flat3;
        if (geo4.flat1)
        begin
            w_w = W_W'(s3_w) - W_W'(m_u13);
            aflat_w = A_W'(q2_w) - A_W'(m_qxu1);
            mulop5_next.td = TD_W'(geo4.v3);
        end
        else
        begin
            w_w = W_W'(s1_w) - W_W'(m_u13);
            aflat_w = A_W'(q2_w) - A_W'(m_qxu3);
            mulop5_next.td = geo4.flat3 ? TD_W'(geo4.v1) : tdg_w;
        end
        asel_w = flat_any_w ? aflat_w : A_W'(q2_w);
        mulop5_next.ame = AE_W'(asel_w) - AE_W'($signed({1'b0, e_w}));
        deg_w = (geo4.flat1 && geo4.flat3)
              || (!flat_any_w && (geo4.zv || (tdg_w == '0)));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s1_w;
            s3_reg <= s3_w;
            w_reg <= w_w;
            geo5_reg <= geo4;
            mulop5_reg <= mulop5_next;
            flat_any5_reg <= flat_any_w;
            deg5_reg <= deg_w;
        end
    end

    logic signed [M2_W-1:0]  m_s1v3, m_s3v1, m_s3u1, m_s1u3;
    logic signed [TNF_W-1:0] m_wqy;

    ict_mul #(.WA(S_W), .WB(DW)) u_m_s1v3 (.clk, .en, .a(s1_reg), .b(geo5_reg.v3), .p(m_s1v3));
    ict_mul #(.WA(S_W), .WB(DW)) u_m_s3v1 (.clk, .en, .a(s3_reg), .b(geo5_reg.v1), .p(m_s3v1));
    ict_mul #(.WA(S_W), .WB(DW)) u_m_s3u1 (.clk, .en, .a(s3_reg), .b(geo5_reg.u1), .p(m_s3u1));
    ict_mul #(.WA(S_W), .WB(DW)) u_m_s1u3 (.clk, .en, .a(s1_reg), .b(geo5_reg.u3), .p(m_s1u3));
    ict_mul #(.WA(W_W), .WB(DW)) u_m_wqy (.clk, .en, .a(w_reg), .b(geo5_reg.qy), .p(m_wqy));

    tail_t tail5;
    tail_t tail9;

    assign tail5.qx = geo5_reg.qx;
    assign tail5.qy = geo5_reg.qy;
    assign tail5.flat_any = flat_any5_reg;
    assign tail5.deg = deg5_reg;

    ict_dly #(.W($bits(tail_t)), .N(4)) u_dly_tail (.clk, .en, .d(tail5), .q(tail9));

    logic signed [G_W-1:0] g1_reg, g2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g1_reg <= G_W'(m_s1v3) - G_W'(m_s3v1);
            g2_reg <= G_W'(m_s3u1) - G_W'(m_s1u3);
        end
    end

    logic signed [M3_W-1:0] m_qxg1, m_qyg2;

    ict_mul #(.WA(G_W), .WB(DW)) u_m_qxg1 (.clk, .en, .a(g1_reg), .b(tail9.qx), .p(m_qxg1));
    ict_mul #(.WA(G_W), .WB(DW)) u_m_qyg2 (.clk, .en, .a(g2_reg), .b(tail9.qy), .p(m_qyg2));

    logic [TNF_W-1:0] tnf12;
    flag_t            flag9;
    flag_t            flag12;
    mulop_t           mulop13;

    assign flag9.flat_any = tail9.flat_any;
    assign flag9.deg = tail9.deg;

    ict_dly #(.W(TNF_W), .N(4)) u_dly_tnf (.clk, .en, .d(m_wqy), .q(tnf12));
    ict_dly #(.W($bits(flag_t)), .N(3)) u_dly_flag (.clk, .en, .d(flag9), .q(flag12));
    ict_dly #(.W($bits(mulop_t)), .N(8)) u_dly_mulop (.clk, .en, .d(mulop5_reg), .q(mulop13));

    fin_t fin13_reg;
    fin_t fin13_next;
    fin_t fin16;

    always_comb
    begin
        if (flag12.flat_any)
            fin13_next.tn = TN_W'($signed(tnf12));
        else
            fin13_next.tn = TN_W'(m_qxg1) + TN_W'(m_qyg2);
        fin13_next.td_neg = 1'b0;
        fin13_next.deg = flag12.deg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            fin13_reg <= fin13_next;
    end

    fin_t fin13_full;

    assign fin13_full.tn = fin13_reg.tn;
    assign fin13_full.td_neg = mulop13.td[TD_W-1];
    assign fin13_full.deg = fin13_reg.deg;

    logic signed [P_W-1:0] m_prod;

    ict_mul #(.WA(AE_W), .WB(TD_W)) u_m_prod (.clk, .en, .a(mulop13.ame), .b(mulop13.td), .p(m_prod));

    ict_dly #(.W($bits(fin_t)), .N(3)) u_dly_fin (.clk, .en, .d(fin13_full), .q(fin16));

    logic signed [R_W-1:0] r_w;
    logic                  inside_w;
    logic                  inside_res_reg;
    logic                  degenerate_reg;

    always_comb
    begin
        r_w = R_W'(m_prod) - R_W'(fin16.tn);
        if (fin16.td_neg)
            inside_w = !r_w[R_W-1];
        else
            inside_w = r_w[R_W-1] || (r_w == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_res_reg <= inside_w && !fin16.deg;
            degenerate_reg <= fin16.deg;
        end
    end

    assign inside_res = inside_res_reg;
    assign degenerate = degenerate_reg;
endmodule
